// ===== rtl/sss_pkg.sv =====
package sss_pkg;

    localparam int RANKS_MAX  = 128;
    localparam int RANK_W     = 8;
    localparam int INDEX_W    = 7;
    localparam int STEP_W     = 3;
    localparam int COUNT_W    = 7;
    localparam int SLICE_MAX  = 64;
    localparam int DESC_DEPTH = 2;
    localparam int DESC_AW    = $clog2(DESC_DEPTH);

    typedef enum logic [1:0] {
        ACT_IDLE = 2'd0,
        ACT_SEND = 2'd1,
        ACT_RECV = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        CFG_RANK_COUNT = 2'd0,
        CFG_OWN_INDEX  = 2'd1,
        CFG_ROOT_INDEX = 2'd2,
        CFG_STEP_TOTAL = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [RANK_W-1:0]  rank_count;
        logic [INDEX_W-1:0] own_index;
        logic [INDEX_W-1:0] root_index;
        logic [STEP_W-1:0]  step_total;
    } cfg_t;

    // One scheduled step as handed from the classifier to the emitter.
    typedef struct packed {
        action_t            action;
        logic [RANK_W-1:0]  peer;
        logic [INDEX_W-1:0] start;
        logic [COUNT_W-1:0] count;
        logic [INDEX_W-1:0] stride_mod;
        logic [RANK_W-1:0]  ranks;
    } desc_t;

endpackage

// ===== rtl/scatter_step_schedule.sv =====
// Works out this rank's part in one step of a binomial-tree scatter. A step
// number pushed in yields one result per slice moved (action, peer, slice
// index, slice count, with last marking the final one), or a single idle result.
// The front classifier first runs a loop that doubles a residue modulo the rank
// count, then classifies the step; the emitter then gives one result per cycle,
// while the consumer keeps popping, for up to 64 slices. A two-entry queue
// between the two lets classification of the next step overlap the emission of
// the current one. Configuration must be written only while nothing is in
// flight; the block itself does not enforce this, and a written register is
// used directly by the classifier, also for a step already in flight.
module scatter_step_schedule (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [1:0]                  cfg_index,
    input  logic [sss_pkg::RANK_W-1:0]  cfg_data,
    input  logic                        push,
    output logic                        full,
    input  logic [sss_pkg::STEP_W-1:0]  step_number,
    output logic                        empty,
    input  logic                        pop,
    output logic [1:0]                  action,
    output logic [sss_pkg::RANK_W-1:0]  peer,
    output logic [sss_pkg::INDEX_W-1:0] slice_index,
    output logic [sss_pkg::COUNT_W-1:0] slice_count,
    output logic                        last
);
    import sss_pkg::*;

    cfg_t  cfg_reg;
    desc_t front_desc;
    desc_t back_desc;
    logic  desc_push;
    logic  desc_full;
    logic  desc_pop;
    logic  desc_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rank_count <= RANK_W'(1);
            cfg_reg.own_index  <= '0;
            cfg_reg.root_index <= '0;
            cfg_reg.step_total <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_RANK_COUNT: cfg_reg.rank_count <= cfg_data;
                CFG_OWN_INDEX:  cfg_reg.own_index  <= cfg_data[INDEX_W-1:0];
                CFG_ROOT_INDEX: cfg_reg.root_index <= cfg_data[INDEX_W-1:0];
                CFG_STEP_TOTAL: cfg_reg.step_total <= cfg_data[STEP_W-1:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    sss_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .push        (push),
        .step_number (step_number),
        .full        (full),
        .desc_push   (desc_push),
        .desc        (front_desc),
        .desc_full   (desc_full)
    );

    sss_desc_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (desc_push),
        .wr_data (front_desc),
        .full    (desc_full),
        .pop     (desc_pop),
        .rd_data (back_desc),
        .empty   (desc_empty)
    );

    sss_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .desc        (back_desc),
        .desc_empty  (desc_empty),
        .desc_pop    (desc_pop),
        .empty       (empty),
        .pop         (pop),
        .action      (action),
        .peer        (peer),
        .slice_index (slice_index),
        .slice_count (slice_count),
        .last        (last)
    );

endmodule

// ===== rtl/sss_desc_fifo.sv =====
module sss_desc_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sss_pkg::desc_t wr_data,
    output logic          full,
    input  logic          pop,
    output sss_pkg::desc_t rd_data,
    output logic          empty
);
    import sss_pkg::*;

    desc_t              mem_reg [DESC_DEPTH];
    logic [DESC_AW-1:0] wr_ptr_reg;
    logic [DESC_AW-1:0] rd_ptr_reg;
    logic [DESC_AW:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == (DESC_AW+1)'(DESC_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/sss_front.sv =====
module sss_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sss_pkg::cfg_t               cfg,
    input  logic                        push,
    input  logic [sss_pkg::STEP_W-1:0]  step_number,
    output logic                        full,
    output logic                        desc_push,
    output sss_pkg::desc_t              desc,
    input  logic                        desc_full
);
    import sss_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ITER,
        ST_CALC
    } state_t;

    state_t              state_reg,  state_next;
    logic [STEP_W-1:0]   step_reg,   step_next;
    logic [STEP_W-1:0]   k_reg,      k_next;
    logic [RANK_W-1:0]   mod_reg,    mod_next;

    logic [RANK_W-1:0]   n;
    logic [RANK_W-1:0]   own8;
    logic [RANK_W-1:0]   root8;
    logic [RANK_W-1:0]   span_unit;
    logic [RANK_W-1:0]   slice_sum;
    logic [RANK_W-1:0]   slices_raw;
    logic [COUNT_W-1:0]  slices;
    logic                pow2;
    logic                is_last;
    logic [RANK_W-1:0]   span;
    logic [RANK_W-1:0]   root_dist;
    logic                bad;
    logic                send;
    logic                recv;
    logic [RANK_W-1:0]   peer_send;
    logic [RANK_W:0]     recv_sum;
    logic [RANK_W-1:0]   peer_recv;
    logic [RANK_W-1:0]   stride_mod;
    logic                active;

    // Doubles a residue modulo n; the residue is always below n.
    function automatic logic [RANK_W-1:0] mod_double(
        input logic [RANK_W-1:0] r,
        input logic [RANK_W-1:0] m
    );
        logic [RANK_W:0] t;
        t = {r, 1'b0};
        if (t >= {1'b0, m})
        begin
            t = t - {1'b0, m};
        end
        return t[RANK_W-1:0];
    endfunction

    always_comb
    begin
        if (cfg.rank_count == '0)
        begin
            n = RANK_W'(1);
        end
        else if (cfg.rank_count > RANK_W'(RANKS_MAX))
        begin
            n = RANK_W'(RANKS_MAX);
        end
        else
        begin
            n = cfg.rank_count;
        end
    end

    assign full      = (state_reg != ST_IDLE);
    assign desc_push = (state_reg == ST_CALC) && !desc_full;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        k_next     = k_reg;
        mod_next   = mod_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (push)
                begin
                    step_next  = step_number;
                    k_next     = '0;
                    mod_next   = (n == RANK_W'(1)) ? '0 : RANK_W'(1);
                    state_next = ST_ITER;
                end
            end
            ST_ITER:
            begin
                if (k_reg == step_reg)
                begin
                    state_next = ST_CALC;
                end
                else
                begin
                    mod_next = mod_double(mod_reg, n);
                    k_next   = k_reg + 1'b1;
                end
            end
            ST_CALC:
            begin
                if (!desc_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            k_reg     <= '0;
            mod_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            k_reg     <= k_next;
            mod_reg   <= mod_next;
        end
    end

    // Classification of the step once the residue of the span unit is known.
    always_comb
    begin
        own8       = {1'b0, cfg.own_index};
        root8      = {1'b0, cfg.root_index};
        span_unit  = RANK_W'(1) << step_reg;
        slice_sum  = n - RANK_W'(1) + span_unit;
        slices_raw = slice_sum >> ({1'b0, step_reg} + 4'd1);
        slices     = (slices_raw > RANK_W'(SLICE_MAX)) ? COUNT_W'(SLICE_MAX)
                                                       : slices_raw[COUNT_W-1:0];
        pow2       = ((n & (n - RANK_W'(1))) == '0);
        is_last    = (cfg.step_total != '0) && (step_reg == cfg.step_total - 1'b1);
        if (!pow2 && is_last)
        begin
            span = (n > span_unit) ? n - span_unit : '0;
        end
        else
        begin
            span = span_unit;
        end
        root_dist  = (root8 >= own8) ? root8 - own8 : root8 + n - own8;
        bad        = (own8 >= n) || (root8 >= n);
        send       = (root_dist < span);
        recv       = !send && (root_dist >= span_unit)
                     && ({1'b0, root_dist} < ({1'b0, span} + {1'b0, span_unit}));
        peer_send  = (own8 >= mod_reg) ? own8 - mod_reg : own8 + n - mod_reg;
        recv_sum   = {1'b0, own8} + {1'b0, mod_reg};
        peer_recv  = (recv_sum >= {1'b0, n}) ? RANK_W'(recv_sum - {1'b0, n})
                                             : recv_sum[RANK_W-1:0];
        stride_mod = mod_double(mod_reg, n);
        active     = !bad && (send || recv) && (slices_raw != '0);

        desc.ranks      = n;
        desc.stride_mod = stride_mod[INDEX_W-1:0];
        if (!active)
        begin
            desc.action = ACT_IDLE;
            desc.peer   = n;
            desc.start  = '0;
            desc.count  = '0;
        end
        else if (send)
        begin
            desc.action = ACT_SEND;
            desc.peer   = peer_send;
            desc.start  = peer_send[INDEX_W-1:0];
            desc.count  = slices;
        end
        else
        begin
            desc.action = ACT_RECV;
            desc.peer   = peer_recv;
            desc.start  = cfg.own_index;
            desc.count  = slices;
        end
    end

endmodule

// ===== rtl/sss_back.sv =====
module sss_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sss_pkg::desc_t              desc,
    input  logic                        desc_empty,
    output logic                        desc_pop,
    output logic                        empty,
    input  logic                        pop,
    output logic [1:0]                  action,
    output logic [sss_pkg::RANK_W-1:0]  peer,
    output logic [sss_pkg::INDEX_W-1:0] slice_index,
    output logic [sss_pkg::COUNT_W-1:0] slice_count,
    output logic                        last
);
    import sss_pkg::*;

    logic                active_reg,      active_next;
    desc_t               cur_reg,         cur_next;
    logic [COUNT_W-1:0]  cnt_reg,         cnt_next;
    logic [INDEX_W-1:0]  idx_reg,         idx_next;
    logic                out_valid_reg,   out_valid_next;
    logic [1:0]          out_action_reg,  out_action_next;
    logic [RANK_W-1:0]   out_peer_reg,    out_peer_next;
    logic [INDEX_W-1:0]  out_index_reg,   out_index_next;
    logic [COUNT_W-1:0]  out_count_reg,   out_count_next;
    logic                out_last_reg,    out_last_next;

    logic                advance;
    logic [RANK_W-1:0]   idx8;
    logic [RANK_W-1:0]   sm8;
    logic [RANK_W-1:0]   idx_wrap;

    assign advance  = !out_valid_reg || pop;
    assign desc_pop = !active_reg && !desc_empty;

    assign idx8     = {1'b0, idx_reg};
    assign sm8      = {1'b0, cur_reg.stride_mod};
    assign idx_wrap = (idx8 >= sm8) ? idx8 - sm8 : idx8 + cur_reg.ranks - sm8;

    always_comb
    begin
        active_next     = active_reg;
        cur_next        = cur_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg;
        out_action_next = out_action_reg;
        out_peer_next   = out_peer_reg;
        out_index_next  = out_index_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;

        if (!active_reg && !desc_empty)
        begin
            active_next = 1'b1;
            cur_next    = desc;
            cnt_next    = (desc.count == '0) ? COUNT_W'(1) : desc.count;
            idx_next    = desc.start;
        end

        if (advance)
        begin
            out_valid_next = active_reg;
            if (active_reg)
            begin
                out_action_next = cur_reg.action;
                out_peer_next   = cur_reg.peer;
                out_index_next  = idx_reg;
                out_count_next  = cur_reg.count;
                out_last_next   = (cnt_reg == COUNT_W'(1));
                idx_next        = idx_wrap[INDEX_W-1:0];
                cnt_next        = cnt_reg - 1'b1;
                if (cnt_reg == COUNT_W'(1))
                begin
                    active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            cur_reg        <= '0;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_action_reg <= '0;
            out_peer_reg   <= '0;
            out_index_reg  <= '0;
            out_count_reg  <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            active_reg     <= active_next;
            cur_reg        <= cur_next;
            cnt_reg        <= cnt_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
            out_action_reg <= out_action_next;
            out_peer_reg   <= out_peer_next;
            out_index_reg  <= out_index_next;
            out_count_reg  <= out_count_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign empty       = !out_valid_reg;
    assign action      = out_action_reg;
    assign peer        = out_peer_reg;
    assign slice_index = out_index_reg;
    assign slice_count = out_count_reg;
    assign last        = out_last_reg;

endmodule
